FILE: design/lagrange_interpolator_defines.svh
// Assertion macros for the Lagrange interpolator.
`ifndef LAGRANGE_INTERPOLATOR_DEFINES_SVH
`define LAGRANGE_INTERPOLATOR_DEFINES_SVH
// Check a property on every clock edge outside reset.
`define LGI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define LGI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

FILE: design/lgi_pkg.sv
// Shared types, constants and codes of the Lagrange interpolator.
`default_nettype none
package lgi_pkg;
  localparam int MAX_NODES  = 8;
  localparam int IDX_W      = $clog2(MAX_NODES);
  localparam int CNT_W      = $clog2(MAX_NODES + 1);
  localparam int FIFO_DEPTH = 2;
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int NUM_W      = 50;
  localparam int DEN_W      = 33;

  localparam logic [3:0]  NODE_COUNT_RST = 4'd6;
  localparam logic signed [63:0] ONE_Q16 = 64'sd65536;
  localparam logic [55:0] ACC_LIMIT = {56{1'b1}};

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_DIVZERO = 2'd1;
  localparam logic [1:0] STAT_SAT     = 2'd2;

  localparam logic REG_NODE_COUNT = 1'b0;

  typedef struct packed {
    logic               cmd;
    logic [2:0]         idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] q;
  } req_t;

  typedef struct packed {
    logic busy;
    logic out_pending;
  } back_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DUPK, ST_DUPI, ST_TK, ST_TI, ST_DIV, ST_MP, ST_MY, ST_FIN, ST_OUT
  } state_e;
endpackage
`default_nettype wire

FILE: design/lgi_front.sv
// Request intake: accepts requests and queues them for the sequencer.
`default_nettype none
module lgi_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     command_i,
  input  wire logic [2:0]               node_index_i,
  input  wire logic signed [31:0]       node_x_i,
  input  wire logic signed [31:0]       node_y_i,
  input  wire logic signed [31:0]       query_x_i,
  output lgi_pkg::req_t                 req_o,
  output logic                          req_valid_o,
  input  wire logic                     req_pop_i,
  output logic [lgi_pkg::FCNT_W-1:0]    count_o
);
  lgi_pkg::req_t                  mem_q [lgi_pkg::FIFO_DEPTH];
  logic                           wr_ptr_q, rd_ptr_q;
  logic [lgi_pkg::FCNT_W-1:0]     cnt_q;
  logic                           push, pop;

  assign in_stall_o  = (cnt_q == lgi_pkg::FCNT_W'(lgi_pkg::FIFO_DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign req_valid_o = (cnt_q != '0);
  assign pop         = req_pop_i && req_valid_o;
  assign req_o       = mem_q[rd_ptr_q];
  assign count_o     = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{cmd: command_i, idx: node_index_i, x: node_x_i,
                           y: node_y_i, q: query_x_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end
endmodule
`default_nettype wire

FILE: design/lgi_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module lgi_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [lgi_pkg::NUM_W-1:0]  num_i,
  input  wire logic signed [lgi_pkg::DEN_W-1:0]  den_i,
  output logic signed [lgi_pkg::NUM_W-1:0]       quo_o,
  output logic                                   done_o
);
  localparam int NM = lgi_pkg::NUM_W - 1;
  localparam int DM = lgi_pkg::DEN_W;

  logic [NM-1:0] nmag_q, quo_q, quo_d;
  logic [DM-1:0] dmag_q;
  logic [DM-1:0] rem_q, rem_d;
  logic [DM:0]   rem_sh;
  logic [5:0]    cnt_q;
  logic          busy_q, neg_q, done_q;
  logic signed [lgi_pkg::NUM_W-1:0] res_q;
  logic signed [lgi_pkg::NUM_W-1:0] num_abs;
  logic signed [lgi_pkg::DEN_W-1:0] den_abs;

  assign num_abs = num_i[lgi_pkg::NUM_W-1] ? -num_i : num_i;
  assign den_abs = den_i[lgi_pkg::DEN_W-1] ? -den_i : den_i;

  always_comb begin
    rem_sh = {rem_q, nmag_q[NM-1]};
    if (rem_sh >= {1'b0, dmag_q}) begin
      rem_d = DM'(rem_sh - {1'b0, dmag_q});
      quo_d = {quo_q[NM-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[DM-1:0];
      quo_d = {quo_q[NM-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nmag_q <= num_abs[NM-1:0];
      dmag_q <= den_abs[DM-1:0];
      rem_q  <= '0;
      quo_q  <= '0;
      neg_q  <= num_i[lgi_pkg::NUM_W-1] ^ den_i[lgi_pkg::DEN_W-1];
    end else if (busy_q) begin
      nmag_q <= {nmag_q[NM-2:0], 1'b0};
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      if (cnt_q == '0) res_q <= neg_q ? -$signed({1'b0, quo_d}) : $signed({1'b0, quo_d});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(NM - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quo_o  = res_q;
  assign done_o = done_q;
endmodule
`default_nettype wire

FILE: design/lgi_mul.sv
// Q16.16 magnitude multiplier over four 32x32 partial products, with clamp.
`default_nettype none
module lgi_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] a_i,
  input  wire logic signed [63:0] b_i,
  output logic signed [63:0]      prod_o,
  output logic                    sat_o,
  output logic                    done_o
);
  logic [63:0]  ua_q, ub_q;
  logic         neg_q, busy_q, done_q, sat_q;
  logic [2:0]   step_q;
  logic [127:0] acc_q, pp_sh;
  logic [63:0]  pp;
  logic [31:0]  opa, opb;
  logic         clamp;
  logic [55:0]  mag;
  logic signed [63:0] res_q;

  assign opa = step_q[1] ? ua_q[63:32] : ua_q[31:0];
  assign opb = step_q[0] ? ub_q[63:32] : ub_q[31:0];
  assign pp  = opa * opb;

  always_comb begin
    unique case (step_q[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  assign clamp = |acc_q[127:72];
  assign mag   = clamp ? lgi_pkg::ACC_LIMIT : acc_q[71:16];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      ub_q  <= b_i[63] ? 64'(-b_i) : 64'(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (busy_q && !step_q[2]) begin
      acc_q <= acc_q + pp_sh;
    end else if (busy_q) begin
      res_q <= neg_q ? -$signed({8'd0, mag}) : $signed({8'd0, mag});
      sat_q <= clamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q[2]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign prod_o = res_q;
  assign sat_o  = sat_q;
  assign done_o = done_q;
endmodule
`default_nettype wire

FILE: design/lgi_back.sv
// Sequencer: node store, duplicate check, basis products and term sum.
`default_nettype none
module lgi_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire lgi_pkg::req_t             req_i,
  input  wire logic                      req_valid_i,
  output logic                           req_pop_o,
  input  wire logic [lgi_pkg::CNT_W-1:0] n_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic signed [31:0]             result_y_o,
  output logic [1:0]                     status_o,
  output lgi_pkg::back_stat_t            stat_o
);
  localparam int IW = lgi_pkg::IDX_W;
  localparam int CW = lgi_pkg::CNT_W;

  lgi_pkg::state_e state_q, state_d;
  logic [31:0]        xs_q [lgi_pkg::MAX_NODES];
  logic [31:0]        ys_q [lgi_pkg::MAX_NODES];
  logic [CW-1:0]      k_q, i_q, k_nx, i_nx;
  logic signed [31:0] xk_q, qx_q, xr, yk, res_q;
  logic signed [31:0] out_y_q;
  logic [1:0]         out_st_q;
  logic signed [63:0] p_q, sum_q, mul_b, mul_res;
  logic [1:0]         stat_q;
  logic               sat_q, out_valid_q;
  logic [IW-1:0]      rd_idx;
  logic signed [32:0] diffq, den;
  logic signed [lgi_pkg::NUM_W-1:0] num, div_res;
  logic               div_start, div_done, mul_start, mul_done, mul_sat, fire;

  assign k_nx   = k_q + 1'b1;
  assign i_nx   = i_q + 1'b1;
  assign rd_idx = (state_q == lgi_pkg::ST_DUPK || state_q == lgi_pkg::ST_TK) ?
                  k_q[IW-1:0] : i_q[IW-1:0];
  assign xr     = $signed(xs_q[rd_idx]);
  assign yk     = $signed(ys_q[k_q[IW-1:0]]);
  assign diffq  = 33'(qx_q) - 33'(xr);
  assign den    = 33'(xk_q) - 33'(xr);
  assign num    = {diffq[32], diffq, 16'd0};
  assign mul_b  = (state_q == lgi_pkg::ST_DIV) ? 64'(div_res) : 64'(yk);

  lgi_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num), .den_i(den),
    .quo_o(div_res), .done_o(div_done)
  );

  lgi_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(p_q), .b_i(mul_b),
    .prod_o(mul_res), .sat_o(mul_sat), .done_o(mul_done)
  );

  always_comb begin
    state_d   = state_q;
    req_pop_o = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    fire      = 1'b0;
    unique case (state_q)
      lgi_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          if (req_i.cmd == lgi_pkg::CMD_EVAL) state_d = lgi_pkg::ST_DUPK;
        end
      end
      lgi_pkg::ST_DUPK: state_d = (k_nx >= n_i) ? lgi_pkg::ST_TK : lgi_pkg::ST_DUPI;
      lgi_pkg::ST_DUPI: begin
        priority if (xr == xk_q) state_d = lgi_pkg::ST_OUT;
        else if (i_nx >= n_i)    state_d = lgi_pkg::ST_DUPK;
        else                     state_d = lgi_pkg::ST_DUPI;
      end
      lgi_pkg::ST_TK: state_d = (k_q >= n_i) ? lgi_pkg::ST_FIN : lgi_pkg::ST_TI;
      lgi_pkg::ST_TI: begin
        if (i_q >= n_i) begin
          mul_start = 1'b1;
          state_d   = lgi_pkg::ST_MY;
        end else if (i_q != k_q) begin
          div_start = 1'b1;
          state_d   = lgi_pkg::ST_DIV;
        end
      end
      lgi_pkg::ST_DIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          state_d   = lgi_pkg::ST_MP;
        end
      end
      lgi_pkg::ST_MP:  if (mul_done) state_d = lgi_pkg::ST_TI;
      lgi_pkg::ST_MY:  if (mul_done) state_d = lgi_pkg::ST_TK;
      lgi_pkg::ST_FIN: state_d = lgi_pkg::ST_OUT;
      lgi_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          fire    = 1'b1;
          state_d = lgi_pkg::ST_IDLE;
        end
      end
      default: state_d = lgi_pkg::ST_IDLE;
    endcase
  end

  // Node store: written by load requests only, never cleared.
  always_ff @(posedge clk_i) begin
    if (state_q == lgi_pkg::ST_IDLE && req_valid_i && req_i.cmd == lgi_pkg::CMD_LOAD &&
        {1'b0, req_i.idx} < 4'(lgi_pkg::MAX_NODES)) begin
      xs_q[req_i.idx[IW-1:0]] <= req_i.x;
      ys_q[req_i.idx[IW-1:0]] <= req_i.y;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lgi_pkg::ST_IDLE: begin
        qx_q  <= req_i.q;
        sum_q <= '0;
      end
      lgi_pkg::ST_DUPK, lgi_pkg::ST_TK: begin
        xk_q <= xr;
        p_q  <= lgi_pkg::ONE_Q16;
      end
      lgi_pkg::ST_DUPI: begin
        res_q  <= '0;
        stat_q <= lgi_pkg::STAT_DIVZERO;
      end
      lgi_pkg::ST_MP: if (mul_done) p_q <= mul_res;
      lgi_pkg::ST_MY: if (mul_done) sum_q <= sum_q + mul_res;
      lgi_pkg::ST_FIN: begin
        priority if (sum_q > 64'sh7FFF_FFFF) begin
          res_q  <= 32'sh7FFF_FFFF;
          stat_q <= lgi_pkg::STAT_SAT;
        end else if (sum_q < -64'sh8000_0000) begin
          res_q  <= 32'sh8000_0000;
          stat_q <= lgi_pkg::STAT_SAT;
        end else begin
          res_q  <= sum_q[31:0];
          stat_q <= sat_q ? lgi_pkg::STAT_SAT : lgi_pkg::STAT_OK;
        end
      end
      default: ;
    endcase
  end

  // Output register: hold the offered result while the next one is worked out.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_y_q  <= res_q;
      out_st_q <= stat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgi_pkg::ST_IDLE;
      k_q         <= '0;
      i_q         <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        lgi_pkg::ST_IDLE: begin
          k_q   <= '0;
          sat_q <= 1'b0;
        end
        lgi_pkg::ST_DUPK: begin
          if (k_nx >= n_i) k_q <= '0;
          else i_q <= k_nx;
        end
        lgi_pkg::ST_DUPI: begin
          if (xr != xk_q) begin
            if (i_nx >= n_i) k_q <= k_nx;
            else i_q <= i_nx;
          end
        end
        lgi_pkg::ST_TK: i_q <= '0;
        lgi_pkg::ST_TI: if (i_q < n_i && i_q == k_q) i_q <= i_nx;
        lgi_pkg::ST_MP: begin
          if (mul_done) begin
            i_q   <= i_nx;
            sat_q <= sat_q | mul_sat;
          end
        end
        lgi_pkg::ST_MY: begin
          if (mul_done) begin
            k_q   <= k_nx;
            sat_q <= sat_q | mul_sat;
          end
        end
        default: ;
      endcase
      if (fire)              out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_y_o         = out_y_q;
  assign status_o           = out_st_q;
  assign stat_o.busy        = (state_q != lgi_pkg::ST_IDLE);
  assign stat_o.out_pending = out_valid_q;
endmodule
`default_nettype wire

FILE: design/lagrange_interpolator.sv
// Top level of the Lagrange interpolator: intake, sequencer and register port.
//
// Requests arrive on the input channel (in_valid_i / in_stall_o) and are taken
// at a clock edge with valid high and stall low. A load request stores one
// node (node_x_i, node_y_i) in slot node_index_i and gives no result. An
// evaluate request gives one result (result_y_o, status_o) on the output
// channel (out_valid_o / out_stall_i) for the first node_count nodes.
// node_count sits at byte address 0 of the APB port; it resets to 6.
// A two-entry request queue decouples intake from the sequencer, so intake
// keeps taking requests, until the queue is full, while the sequencer works
// or a result waits. The sequencer uses a serial divider for each ratio and
// a four-pass multiplier for each product, and handles a load in its idle
// state. Equal abscissas end an evaluate early. A result waits in its output
// register while out_stall_i is high; the sequencer holds once its next
// result is ready, and the queue then fills before in_stall_o rises.
// Reset clears the control state and the queue; the node store is left
// undefined until written.
`default_nettype none
`include "lagrange_interpolator_defines.svh"
module lagrange_interpolator (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               command_i,
  input  wire logic [2:0]         node_index_i,
  input  wire logic signed [31:0] node_x_i,
  input  wire logic signed [31:0] node_y_i,
  input  wire logic signed [31:0] query_x_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      result_y_o,
  output logic [1:0]              status_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  lgi_pkg::req_t                 req;
  lgi_pkg::back_stat_t           be_stat;
  logic                          req_valid, req_pop;
  logic [lgi_pkg::FCNT_W-1:0]    fe_cnt;
  logic [3:0]                    ncnt_q;
  logic [lgi_pkg::CNT_W-1:0]     n_eff;

  // Register port: always ready, one register at byte address 0.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lgi_pkg::REG_NODE_COUNT) ? {28'd0, ncnt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncnt_q <= lgi_pkg::NODE_COUNT_RST;
    end else if (psel && penable && pwrite && paddr[2] == lgi_pkg::REG_NODE_COUNT) begin
      ncnt_q <= pwdata[3:0];
    end
  end

  // Clamp the node count into one to the full store.
  always_comb begin
    priority if (ncnt_q == '0)                   n_eff = lgi_pkg::CNT_W'(1);
    else if (ncnt_q > 4'(lgi_pkg::MAX_NODES))    n_eff = lgi_pkg::CNT_W'(lgi_pkg::MAX_NODES);
    else                                         n_eff = lgi_pkg::CNT_W'(ncnt_q);
  end

  lgi_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .node_index_i,
    .node_x_i, .node_y_i, .query_x_i, .req_o(req), .req_valid_o(req_valid),
    .req_pop_i(req_pop), .count_o(fe_cnt)
  );

  lgi_back u_back (
    .clk_i, .rst_ni, .req_i(req), .req_valid_i(req_valid), .req_pop_o(req_pop),
    .n_i(n_eff), .out_valid_o, .out_stall_i, .result_y_o, .status_o, .stat_o(be_stat)
  );

  `LGI_ASSERT(a_queue_bound, fe_cnt <= lgi_pkg::FCNT_W'(lgi_pkg::FIFO_DEPTH), "queue overfilled")
  `LGI_ASSERT(a_divzero_zero, out_valid_o && status_o == lgi_pkg::STAT_DIVZERO |-> result_y_o == 32'sd0, "nonzero result on equal abscissas")
  `LGI_ASSERT(a_result_from_seq, $rose(out_valid_o) |-> $past(be_stat.busy), "result without active evaluate")
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the Lagrange interpolator top level.
`timescale 1ns / 100ps
module tb;
  localparam int CYCLE_LIMIT = 20000000;
  // Wait after draining: covers a load still in the request queue and sequencer.
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic signed [31:0] y;
    logic [1:0]         st;
  } interp_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Request channel
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               command_i = lgi_pkg::CMD_LOAD;
  logic [2:0]         node_index_i = '0;
  logic signed [31:0] node_x_i = '0;
  logic signed [31:0] node_y_i = '0;
  logic signed [31:0] query_x_i = '0;

  // Result channel
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] result_y_o;
  logic [1:0]         status_o;

  // Register port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lagrange_interpolator dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .command_i, .node_index_i, .node_x_i, .node_y_i, .query_x_i,
    .out_valid_o, .out_stall_i, .result_y_o, .status_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Predictor state: a private copy of the node store and the node count.
  logic signed [31:0] node_x_mem [lgi_pkg::MAX_NODES];
  logic signed [31:0] node_y_mem [lgi_pkg::MAX_NODES];
  logic [3:0]         active_count = lgi_pkg::NODE_COUNT_RST;

  interp_result_t pending_results [$];
  int mismatch_count = 0;
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  longint cycle_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Abort on a hang.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("** lagrange_interpolator: FAILED **");
      $finish;
    end
  end

  // Q16.16 multiply on magnitudes, truncate toward zero, clamp to ACC_LIMIT.
  function automatic longint q16_mul(longint a, longint b, inout bit sat);
    logic [63:0]  ua, ub;
    logic [127:0] prod;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    prod = {64'd0, ua} * {64'd0, ub};
    prod = prod >> 16;
    if (prod > {72'd0, lgi_pkg::ACC_LIMIT}) begin
      prod = {72'd0, lgi_pkg::ACC_LIMIT};
      sat = 1'b1;
    end
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  // Interpolate at qx over the nodes in use.
  function automatic interp_result_t interp_eval(logic signed [31:0] qx);
    interp_result_t res;
    int     n;
    longint sum, p, r, xk, xi, q;
    bit     sat;
    n = active_count;
    if (n < 1) n = 1;
    if (n > lgi_pkg::MAX_NODES) n = lgi_pkg::MAX_NODES;
    // Equal abscissas end the evaluation before any product.
    for (int k = 0; k < n; k++)
      for (int i = k + 1; i < n; i++)
        if (node_x_mem[k] == node_x_mem[i]) begin
          res.y = '0;
          res.st = lgi_pkg::STAT_DIVZERO;
          return res;
        end
    sat = 1'b0;
    sum = 0;
    q = longint'(qx);
    for (int k = 0; k < n; k++) begin
      xk = longint'(node_x_mem[k]);
      p = 65536;
      for (int i = 0; i < n; i++) begin
        if (i != k) begin
          xi = longint'(node_x_mem[i]);
          r = ((q - xi) * 65536) / (xk - xi);
          p = q16_mul(p, r, sat);
        end
      end
      sum += q16_mul(p, longint'(node_y_mem[k]), sat);
    end
    if (sum > 64'sh7FFF_FFFF) begin
      sum = 64'sh7FFF_FFFF;
      sat = 1'b1;
    end else if (sum < -64'sh8000_0000) begin
      sum = -64'sh8000_0000;
      sat = 1'b1;
    end
    res.y = sum[31:0];
    res.st = sat ? lgi_pkg::STAT_SAT : lgi_pkg::STAT_OK;
    return res;
  endfunction

  // Offer one request; call and return at a falling edge, valid stays high.
  task automatic send_request(logic cmd, logic [2:0] idx, logic signed [31:0] x,
                              logic signed [31:0] y, logic signed [31:0] q);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    node_index_i <= idx;
    node_x_i     <= x;
    node_y_i     <= y;
    query_x_i    <= q;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
    end
    // Update the predictor at acceptance so order matches the block.
    if (cmd == lgi_pkg::CMD_LOAD) begin
      node_x_mem[idx] = x;
      node_y_mem[idx] = y;
    end else begin
      pending_results.push_back(interp_eval(q));
    end
    @(negedge clk_i);
  endtask

  task automatic load_node(int idx, logic signed [31:0] x, logic signed [31:0] y);
    send_request(lgi_pkg::CMD_LOAD, idx[2:0], x, y, $urandom);
  endtask

  task automatic evaluate(logic signed [31:0] q);
    send_request(lgi_pkg::CMD_EVAL, 3'($urandom), $urandom, $urandom, q);
  endtask

  // Drop valid and wait until every result is back and the sequencer is quiet.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // APB write: setup phase, then access phase; pready is always high.
  task automatic write_node_count(logic [3:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(lgi_pkg::REG_NODE_COUNT * 4);
    pwdata  <= {28'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    active_count = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random Q16.16 value, mostly of moderate size, sometimes full range.
  function automatic logic signed [31:0] rand_q16();
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(0, 24);
  endfunction

  // Result side: random stall, or a long hold when one is requested.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (mismatch_count++ < 10)
          $display("unexpected result y=%h status=%0d", result_y_o, status_o);
      end else begin
        interp_result_t exp_res;
        exp_res = pending_results.pop_front();
        if (result_y_o !== exp_res.y || status_o !== exp_res.st) begin
          error_count++;
          if (mismatch_count++ < 10)
            $display("mismatch: expected y=%h status=%0d, got y=%h status=%0d",
                     exp_res.y, exp_res.st, result_y_o, status_o);
        end
      end
    end
  end

  // Fill every slot, then evaluate at nodes, between nodes and at extremes.
  task automatic test_basic;
    for (int k = 0; k < lgi_pkg::MAX_NODES; k++)
      load_node(k, (k - 3) <<< 16, (k * 3 - 7) <<< 15);
    evaluate(32'sh0000_0000);
    evaluate(32'sh0001_8000);
    evaluate(32'sh7FFF_FFFF);
    evaluate(32'sh8000_0000);
    // Extreme ordinates: overflow of the sum.
    load_node(2, 32'sh0000_0000, 32'sh7FFF_FFFF);
    load_node(3, 32'sh0001_0000, 32'sh8000_0000);
    evaluate(32'sh0040_0000);
    evaluate(32'sh0000_0000);
  endtask

  // Equal abscissas, a single node, and out-of-range node counts.
  task automatic test_special;
    load_node(1, 32'sh0000_0000, 32'sh0003_0000);
    evaluate(32'sh0002_0000);
    load_node(1, 32'sh8000_0000, 32'sh0003_0000);
    load_node(0, 32'sh7FFF_FFFF, 32'sh1234_5678);
    evaluate(32'sh0000_1000);
    drain();
    write_node_count(4'd1);
    evaluate(32'sh1000_0000);
    drain();
    write_node_count(4'd0);
    evaluate(32'shF000_0000);
    drain();
    write_node_count(4'd15);
    evaluate(32'sh0002_0000);
    drain();
  endtask

  // Hold the result side while requests keep coming, then pause until drained.
  task automatic test_backpressure;
    write_node_count(4'd3);
    hold_left = 400;
    for (int k = 0; k < 10; k++) begin
      if (k % 2 == 0) load_node(k % 3, rand_q16(), rand_q16());
      else evaluate(rand_q16());
    end
    drain();
  endtask

  // Random traffic under one node count.
  task automatic test_random(logic [3:0] count, int items);
    drain();
    write_node_count(count);
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(99) < 65) load_node($urandom_range(0, 7), rand_q16(), rand_q16());
      else evaluate(rand_q16());
    end
  endtask

  initial begin
    for (int k = 0; k < lgi_pkg::MAX_NODES; k++) begin
      node_x_mem[k] = '0;
      node_y_mem[k] = '0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_basic();
    drain();
    test_special();
    test_backpressure();

    send_idle_pct = 14;
    recv_idle_pct = 85;
    test_random(4'd3, 130);
    test_random(4'd8, 60);
    test_random(4'd1, 190);

    send_idle_pct = 85;
    recv_idle_pct = 14;
    test_random(4'd2, 130);
    test_random(4'd0, 100);
    test_random(4'd5, 150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(4'd4, 150);
    test_random(4'd15, 40);
    test_random(4'd7, 90);
    test_random(4'd6, 100);

    drain();
    repeat (50) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("** lagrange_interpolator: PASSED **");
    end else begin
      $display("** lagrange_interpolator: FAILED **");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+design
design/lgi_pkg.sv
design/lgi_front.sv
design/lgi_div.sv
design/lgi_mul.sv
design/lgi_back.sv
design/lagrange_interpolator.sv
tb/sv/tb.sv
